### src/ousl_pkg.sv
// Shared types and constants for the ordered unique slot list.
`default_nettype none
package ousl_pkg;

	localparam int FIELD_W   = 16;
	localparam int OP_W      = 2;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_ERASE  = 2'd1,
		OP_MOVE   = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic encode;
		logic update;
	} cmd_t;

endpackage
`default_nettype wire

### src/ousl_if.sv
// Request and response channel interfaces of the ordered unique slot list.
`default_nettype none
interface ousl_req_if;
	logic                         valid;
	logic                         ready;
	logic [ousl_pkg::OP_W-1:0]    op;
	logic [ousl_pkg::FIELD_W-1:0] slot_id;
	logic [ousl_pkg::FIELD_W-1:0] layer_id;
	logic [ousl_pkg::FIELD_W-1:0] before_slot_id;
	logic                         before_is_end;

	modport source (output valid, op, slot_id, layer_id, before_slot_id, before_is_end,
		input ready);
	modport sink (input valid, op, slot_id, layer_id, before_slot_id, before_is_end,
		output ready);
endinterface

interface ousl_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           ok;
	logic [ousl_pkg::FIELD_W-1:0]   found_layer;
	logic [ousl_pkg::CNT_OUT_W-1:0] entry_count;

	modport source (output valid, ok, found_layer, entry_count, input ready);
	modport sink (input valid, ok, found_layer, entry_count, output ready);
endinterface
`default_nettype wire

### src/ordered_unique_slot_list.sv
// Top level of the ordered unique slot list: controller plus datapath.
// Usage:
//   req carries one transaction per operation: op (append, erase, move before,
//   find), slot_id, layer_id, before_slot_id and before_is_end. rsp returns
//   exactly one transaction per request: ok, found_layer and entry_count.
// Timing:
//   A request is taken when req.valid and req.ready are high; that edge
//   captures it. The response is valid after the key compare over all
//   entries, the position encode, and one shift update of the entry arrays
//   that also loads the response register. req.ready is high only in the
//   idle state, so one request is in flight at a time and the block takes
//   no new request until the capture-compare-encode-update sequence of the
//   last one is through.
// Stall:
//   A finished response waits in the output register while rsp.ready is low;
//   the next request is still taken and runs up to its update, which holds
//   until the pending response is taken.
// Reset:
//   arst_n clears the entry count and all handshake state. Entry storage is
//   not cleared; entries beyond the count never take part in a compare.
`default_nettype none
module ordered_unique_slot_list #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ousl_req_if.sink  req,
	ousl_rsp_if.source rsp
);

	ousl_pkg::cmd_t cmd;

	ousl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	ousl_dp #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.req_op             (req.op),
		.req_slot_id        (req.slot_id),
		.req_layer_id       (req.layer_id),
		.req_before_slot_id (req.before_slot_id),
		.req_before_is_end  (req.before_is_end),
		.rsp_ok             (rsp.ok),
		.rsp_found_layer    (rsp.found_layer),
		.rsp_entry_count    (rsp.entry_count)
	);

endmodule
`default_nettype wire

### src/ousl_ctrl.sv
// Controller: sequences compare, encode and update, and owns the handshakes.
`default_nettype none
module ousl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ousl_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_ENC,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.compare = (state_q == ST_CMP);
		cmd.encode  = (state_q == ST_ENC);
		cmd.update  = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_ENC;
				ST_ENC: state_q <= ST_UPD;
				ST_UPD: begin
					if (cmd.update) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.compare, cmd.encode, cmd.update}))
		else $error("more than one datapath command at once");

	a_hold_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && out_valid_q && !out_ready) |=> (state_q == ST_UPD))
		else $error("update applied while response still pending");

	a_capture_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_CMP && !in_ready))
		else $error("capture not followed by compare");

endmodule
`default_nettype wire

### src/ousl_dp.sv
// Datapath: entry arrays, parallel key compare, position encode and shift update.
`default_nettype none
module ousl_dp #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ousl_pkg::cmd_t                 cmd,
	input  wire logic [ousl_pkg::OP_W-1:0]      req_op,
	input  wire logic [ousl_pkg::FIELD_W-1:0]   req_slot_id,
	input  wire logic [ousl_pkg::FIELD_W-1:0]   req_layer_id,
	input  wire logic [ousl_pkg::FIELD_W-1:0]   req_before_slot_id,
	input  wire logic                           req_before_is_end,
	output logic                                rsp_ok,
	output logic [ousl_pkg::FIELD_W-1:0]        rsp_found_layer,
	output logic [ousl_pkg::CNT_OUT_W-1:0]      rsp_entry_count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [ID_BITS-1:0] key_q [DEPTH];
	logic [ID_BITS-1:0] lay_q [DEPTH];
	logic [CNT_W-1:0]   count_q;

	ousl_pkg::op_t      op_q;
	logic [ID_BITS-1:0] sk_q;
	logic [ID_BITS-1:0] ly_q;
	logic [ID_BITS-1:0] bf_q;
	logic               end_q;

	logic [DEPTH-1:0]   hit_key_s1;
	logic [DEPTH-1:0]   hit_lay_s1;
	logic [DEPTH-1:0]   hit_bf_s1;

	logic [IDX_W-1:0]   pos_s2;
	logic [IDX_W-1:0]   tgt_s2;
	logic               key_hit_s2;
	logic               lay_hit_s2;
	logic               bf_hit_s2;
	logic [ID_BITS-1:0] mv_lay_s2;

	logic [IDX_W-1:0]   pos_enc;
	logic [IDX_W-1:0]   tgt_enc;
	logic [ID_BITS-1:0] mv_lay_enc;

	logic               ok;
	logic               do_load;
	logic               do_move;
	logic               do_erase;
	logic [IDX_W-1:0]   load_idx;
	logic [ID_BITS-1:0] load_key;
	logic [ID_BITS-1:0] load_lay;
	logic [CNT_W-1:0]   new_count;
	logic [ID_BITS-1:0] found;

	logic [ID_BITS-1:0] key_nxt [DEPTH];
	logic [ID_BITS-1:0] lay_nxt [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= ousl_pkg::op_t'(req_op);
			sk_q  <= ID_BITS'(req_slot_id);
			ly_q  <= ID_BITS'(req_layer_id);
			bf_q  <= ID_BITS'(req_before_slot_id);
			end_q <= req_before_is_end;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
		logic live;
		assign live = (CNT_W'(i) < count_q);
		always_ff @(posedge clk) begin
			if (cmd.compare) begin
				hit_key_s1[i] <= live && (key_q[i] == sk_q);
				hit_lay_s1[i] <= live && (lay_q[i] == ly_q);
				hit_bf_s1[i]  <= live && (key_q[i] == bf_q);
			end
		end
	end

	always_comb begin
		pos_enc    = '0;
		tgt_enc    = '0;
		mv_lay_enc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos_enc    = pos_enc | (hit_key_s1[i] ? IDX_W'(i) : '0);
			tgt_enc    = tgt_enc | (hit_bf_s1[i] ? IDX_W'(i) : '0);
			mv_lay_enc = mv_lay_enc | (hit_key_s1[i] ? lay_q[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.encode) begin
			pos_s2     <= pos_enc;
			tgt_s2     <= tgt_enc;
			key_hit_s2 <= |hit_key_s1;
			lay_hit_s2 <= |hit_lay_s1;
			bf_hit_s2  <= |hit_bf_s1;
			mv_lay_s2  <= mv_lay_enc;
		end
	end

	always_comb begin
		ok        = 1'b0;
		do_load   = 1'b0;
		do_move   = 1'b0;
		do_erase  = 1'b0;
		load_idx  = IDX_W'(count_q);
		load_key  = sk_q;
		load_lay  = ly_q;
		new_count = count_q;
		found     = '0;
		case (op_q)
			ousl_pkg::OP_APPEND: begin
				if (sk_q != '0 && ly_q != '0 && !key_hit_s2 && !lay_hit_s2 &&
						count_q < CNT_W'(DEPTH)) begin
					ok        = 1'b1;
					do_load   = 1'b1;
					new_count = count_q + CNT_W'(1);
				end
			end
			ousl_pkg::OP_ERASE: begin
				if (sk_q != '0 && key_hit_s2) begin
					ok        = 1'b1;
					do_erase  = 1'b1;
					new_count = count_q - CNT_W'(1);
				end
			end
			ousl_pkg::OP_MOVE: begin
				if (sk_q != '0 && key_hit_s2) begin
					if (!end_q && bf_q == sk_q) begin
						ok = 1'b1;
					end else if (end_q || (bf_q != '0 && bf_hit_s2)) begin
						ok       = 1'b1;
						do_load  = 1'b1;
						do_move  = 1'b1;
						load_lay = mv_lay_s2;
						if (end_q) begin
							load_idx = IDX_W'(count_q - CNT_W'(1));
						end else if (tgt_s2 > pos_s2) begin
							load_idx = tgt_s2 - IDX_W'(1);
						end else begin
							load_idx = tgt_s2;
						end
					end
				end
			end
			ousl_pkg::OP_FIND: begin
				if (sk_q != '0 && key_hit_s2) begin
					ok    = 1'b1;
					found = mv_lay_s2;
				end
			end
			default: ok = 1'b0;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_upd
		localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
		logic [ID_BITS-1:0] dn_key;
		logic [ID_BITS-1:0] dn_lay;
		logic [ID_BITS-1:0] up_key;
		logic [ID_BITS-1:0] up_lay;
		logic               sel_load;
		logic               sel_dn;
		logic               sel_up;

		if (i < DEPTH - 1) begin : g_dn
			assign dn_key = key_q[i+1];
			assign dn_lay = lay_q[i+1];
		end else begin : g_dn_top
			assign dn_key = key_q[i];
			assign dn_lay = lay_q[i];
		end
		if (i > 0) begin : g_up
			assign up_key = key_q[i-1];
			assign up_lay = lay_q[i-1];
		end else begin : g_up_bot
			assign up_key = key_q[i];
			assign up_lay = lay_q[i];
		end

		always_comb begin
			sel_load = do_load && (IDX == load_idx);
			sel_dn   = (do_erase && IDX >= pos_s2) ||
				(do_move && pos_s2 < load_idx && IDX >= pos_s2 && IDX < load_idx);
			sel_up   = do_move && pos_s2 > load_idx && IDX > load_idx && IDX <= pos_s2;
			if (sel_load) begin
				key_nxt[i] = load_key;
				lay_nxt[i] = load_lay;
			end else if (sel_dn) begin
				key_nxt[i] = dn_key;
				lay_nxt[i] = dn_lay;
			end else if (sel_up) begin
				key_nxt[i] = up_key;
				lay_nxt[i] = up_lay;
			end else begin
				key_nxt[i] = key_q[i];
				lay_nxt[i] = lay_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				key_q[i] <= key_nxt[i];
				lay_q[i] <= lay_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			count_q <= new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rsp_ok          <= ok;
			rsp_found_layer <= ousl_pkg::FIELD_W'(found);
			rsp_entry_count <= ousl_pkg::CNT_OUT_W'(new_count);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && op_q == ousl_pkg::OP_APPEND && ok) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted append did not grow the list");

	a_move_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && (op_q == ousl_pkg::OP_MOVE || op_q == ousl_pkg::OP_FIND)) |=>
		$stable(count_q))
		else $error("move or find changed the entry count");

endmodule
`default_nettype wire
